[hdl/smpq_pkg.sv]
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and codes for the stable minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;

    localparam logic [STATUS_W-1:0] ST_INSERTED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL_DROP  = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic                     we;
        logic                     re;
    } mem_ctl_t;

endpackage

[hdl/smpq_mem.sv]
// ----------------------------------------------------------------------------
// smpq_mem
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module smpq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 clk,
    input  smpq_pkg::mem_ctl_t   ctl,
    input  logic [AW-1:0]        waddr,
    input  smpq_pkg::entry_t     wdata,
    input  logic [AW-1:0]        raddr,
    output smpq_pkg::entry_t     rdata
);
    import smpq_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/stable_min_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// stable_min_priority_queue_core
// Bounded priority queue kept as a sorted ring in one memory; inserts walk
// back from the tail, shifting larger entries up one slot.
// ----------------------------------------------------------------------------
//  channel  | handshake           | fields
//  ---------+---------------------+-------------------------------------------
//  command  | start / busy        | mode, item_value, item_priority
//  result   | done (1-cycle)      | status, removed_value, removed_priority,
//           |                     | occupancy
//
//  Full insert, empty remove, insert into an empty queue: result in the cycle
//  after acceptance, busy stays low. Remove: head read, S_POP, registered
//  result. Insert: S_SCAN steps back one larger entry at a time, then S_SCAN
//  or S_PLACE writes the item; the single memory read port sets that pace.
//  busy is high while it runs. Reset empties the queue at once; memory
//  contents are not cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic                                     mode,
    input  logic signed [smpq_pkg::DATA_W-1:0]       item_value,
    input  logic signed [smpq_pkg::DATA_W-1:0]       item_priority,
    output logic                                     done,
    output logic [smpq_pkg::STATUS_W-1:0]            status,
    output logic signed [smpq_pkg::DATA_W-1:0]       removed_value,
    output logic signed [smpq_pkg::DATA_W-1:0]       removed_priority,
    output logic [smpq_pkg::OCC_W-1:0]               occupancy
);
    import smpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [AW:0]   CAP_WIDE = (AW + 1)'(CAPACITY);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_PLACE = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic [CW-1:0]            left_reg, left_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] pri_reg, pri_next;
    logic                     done_reg, done_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [DATA_W-1:0] rv_reg, rv_next;
    logic signed [DATA_W-1:0] rp_reg, rp_next;
    logic [OCC_W-1:0]         occ_reg, occ_next;

    mem_ctl_t                 mem_ctl;
    logic [AW-1:0]            mem_waddr;
    entry_t                   mem_wdata;
    logic [AW-1:0]            mem_raddr;
    entry_t                   mem_rdata;

    logic [CW-1:0]            count_m1;
    logic [AW:0]              tail_sum;
    logic [AW-1:0]            tail_idx;
    logic [AW-1:0]            pos_inc;
    logic [AW-1:0]            pos_dec;
    logic [AW-1:0]            head_inc;

    smpq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign count_m1 = count_reg - CW'(1);
    assign tail_sum = (AW + 1)'(head_reg) + (AW + 1)'(count_m1);
    assign tail_idx = (tail_sum >= CAP_WIDE) ? AW'(tail_sum - CAP_WIDE) : AW'(tail_sum);
    assign pos_inc  = (pos_reg == LAST_IDX) ? '0 : pos_reg + AW'(1);
    assign pos_dec  = (pos_reg == '0) ? LAST_IDX : pos_reg - AW'(1);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        left_next   = left_reg;
        val_next    = val_reg;
        pri_next    = pri_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rv_next     = rv_reg;
        rp_next     = rp_reg;
        mem_ctl     = '0;
        mem_waddr   = pos_inc;
        mem_wdata   = mem_rdata;
        mem_raddr   = pos_dec;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next = item_value;
                    pri_next = item_priority;
                    rv_next  = '0;
                    rp_next  = '0;
                    if (mode)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            mem_ctl.re = 1'b1;
                            mem_raddr  = head_reg;
                            state_next = S_POP;
                        end
                    end
                    else
                    begin
                        if (count_reg >= CAP_CNT)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL_DROP;
                        end
                        else if (count_reg == '0)
                        begin
                            mem_ctl.we      = 1'b1;
                            mem_waddr       = head_reg;
                            mem_wdata.value = item_value;
                            mem_wdata.prio  = item_priority;
                            count_next      = count_reg + CW'(1);
                            done_next       = 1'b1;
                            status_next     = ST_INSERTED;
                        end
                        else
                        begin
                            mem_ctl.re = 1'b1;
                            mem_raddr  = tail_idx;
                            pos_next   = tail_idx;
                            left_next  = count_m1;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_POP:
            begin
                rv_next     = mem_rdata.value;
                rp_next     = mem_rdata.prio;
                head_next   = head_inc;
                count_next  = count_m1;
                done_next   = 1'b1;
                status_next = ST_REMOVED;
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                mem_ctl.we = 1'b1;
                mem_waddr  = pos_inc;
                if (mem_rdata.prio > pri_reg)
                begin
                    mem_wdata = mem_rdata;
                    if (left_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        mem_ctl.re = 1'b1;
                        mem_raddr  = pos_dec;
                        pos_next   = pos_dec;
                        left_next  = left_reg - CW'(1);
                    end
                end
                else
                begin
                    mem_wdata.value = val_reg;
                    mem_wdata.prio  = pri_reg;
                    count_next      = count_reg + CW'(1);
                    done_next       = 1'b1;
                    status_next     = ST_INSERTED;
                    state_next      = S_IDLE;
                end
            end
            S_PLACE:
            begin
                mem_ctl.we      = 1'b1;
                mem_waddr       = pos_reg;
                mem_wdata.value = val_reg;
                mem_wdata.prio  = pri_reg;
                count_next      = count_reg + CW'(1);
                done_next       = 1'b1;
                status_next     = ST_INSERTED;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        occ_next = done_next ? OCC_W'(count_next) : occ_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_INSERTED;
            rv_reg     <= '0;
            rp_reg     <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            rv_reg     <= rv_next;
            rp_reg     <= rp_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        left_reg <= left_next;
        val_reg  <= val_next;
        pri_reg  <= pri_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign status           = status_reg;
    assign removed_value    = rv_reg;
    assign removed_priority = rp_reg;
    assign occupancy        = occ_reg;

endmodule
